// File: src/assert_macros.svh
// Assertion macros shared by the detector's modules.
// Both sample on clk and are switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge.
`define REND_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rend assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define REND_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rend assertion failed");

`endif

// File: src/rend_pkg.sv
// Types, constants and helpers for the repeated-extreme no-data detector.
// No dependencies.
package rend_pkg;

  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned CNT_W     = 25;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(25'd16777216);
  localparam logic [CNT_W-1:0] MIN_TOTAL = CNT_W'(3);
  localparam logic [CNT_W-1:0] MIN_REPEATS = CNT_W'(16);

  localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] FIX_ONE  = 64'd1 << FRAC_BITS;
  localparam logic [VAL_W-1:0] FIX_MEGA = 64'd1000000 << FRAC_BITS;
  // Largest operands whose products by 100 and 10000 still fit in 64 bits
  localparam logic [VAL_W-1:0] SEP_LIM  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd100;
  localparam logic [VAL_W-1:0] LIM_LIM  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd10000;

  // Running frame statistics
  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [VAL_W-1:0] lo;
    logic [CNT_W-1:0] lo_rep;
    logic [VAL_W-1:0] hi;
    logic [CNT_W-1:0] hi_rep;
    logic [VAL_W-1:0] above_lo;
    logic [VAL_W-1:0] below_hi;
    logic             above_ok;
    logic             below_ok;
  } stat_t;

  function automatic logic lt_s(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    lt_s = $signed(a) < $signed(b);
  endfunction

  function automatic logic [VAL_W-1:0] mag(input logic [VAL_W-1:0] a);
    mag = a[VAL_W-1] ? (~a + 64'd1) : a;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c < MAX_COUNT) ? c + CNT_W'(1) : c;
  endfunction

  // Constant products, only used below the saturation limit
  function automatic logic [VAL_W-1:0] mul100(input logic [VAL_W-1:0] x);
    mul100 = (x << 6) + (x << 5) + (x << 2);
  endfunction

  function automatic logic [VAL_W-1:0] mul10000(input logic [VAL_W-1:0] x);
    mul10000 = (x << 13) + (x << 10) + (x << 9) + (x << 8) + (x << 4);
  endfunction

endpackage

// File: src/rend_accum.sv
// Running statistics of one frame: count, extremes, repeats, runners-up.
// Depends on rend_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rend_accum
  import rend_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [VAL_W-1:0] sample,
  input  logic             sample_finite,
  input  logic             frame_last,
  output stat_t            upd
);

  stat_t stats;
  stat_t stats_next;

  always_comb begin
    upd = stats;
    if (sample_finite) begin
      if (stats.total == '0) begin
        upd.lo     = sample;
        upd.hi     = sample;
        upd.lo_rep = CNT_W'(1);
        upd.hi_rep = CNT_W'(1);
        upd.total  = CNT_W'(1);
      end else begin
        upd.total = sat_inc(stats.total);
        priority if (lt_s(sample, stats.lo)) begin
          upd.above_lo = stats.lo;
          upd.above_ok = 1'b1;
          upd.lo       = sample;
          upd.lo_rep   = CNT_W'(1);
        end else if (sample == stats.lo) begin
          upd.lo_rep = sat_inc(stats.lo_rep);
        end else if (!stats.above_ok || lt_s(sample, stats.above_lo)) begin
          upd.above_lo = sample;
          upd.above_ok = 1'b1;
        end else begin
          upd.above_lo = stats.above_lo;
        end
        priority if (lt_s(stats.hi, sample)) begin
          upd.below_hi = stats.hi;
          upd.below_ok = 1'b1;
          upd.hi       = sample;
          upd.hi_rep   = CNT_W'(1);
        end else if (sample == stats.hi) begin
          upd.hi_rep = sat_inc(stats.hi_rep);
        end else if (!stats.below_ok || lt_s(stats.below_hi, sample)) begin
          upd.below_hi = sample;
          upd.below_ok = 1'b1;
        end else begin
          upd.below_hi = stats.below_hi;
        end
      end
    end
  end

  // the frame's last item hands its statistics on and starts afresh
  always_comb begin
    stats_next = stats;
    if (take) begin
      stats_next = frame_last ? '0 : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= '0;
    end else begin
      stats <= stats_next;
    end
  end

  `REND_ASSERT_ALWAYS(a_order, (stats.total == '0) || !lt_s(stats.hi, stats.lo))
  `REND_ASSERT_ALWAYS(a_reps, (stats.lo_rep <= stats.total) && (stats.hi_rep <= stats.total))
  `REND_ASSERT_NEXT(a_clear, take && frame_last, stats.total == '0)

endmodule

// File: src/rend_judge.sv
// Decision pipeline: differences and scales, saturated limits, final tests.
// Three register stages, the last one is the result register.
// Depends on rend_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rend_judge
  import rend_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             snap_valid,
  input  stat_t            snap,
  output logic             snap_ready,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             nodata_found,
  output logic             found_at_maximum,
  output logic [VAL_W-1:0] nodata_value
);

  typedef struct packed {
    logic             gate;
    logic             lo_cand;
    logic             hi_cand;
    logic             range_ok;
    logic [VAL_W-1:0] range;
    logic [VAL_W-1:0] dist_lo;
    logic [VAL_W-1:0] dist_hi;
    logic [VAL_W-1:0] mag_lo;
    logic [VAL_W-1:0] mag_hi;
    logic [VAL_W-1:0] scale_lo;
    logic [VAL_W-1:0] scale_hi;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
  } diff_t;

  typedef struct packed {
    logic             gate;
    logic             lo_cand;
    logic             hi_cand;
    logic [VAL_W-1:0] sep;
    logic [VAL_W-1:0] dist_lo;
    logic [VAL_W-1:0] dist_hi;
    logic [VAL_W-1:0] mag_lo;
    logic [VAL_W-1:0] mag_hi;
    logic [VAL_W-1:0] lim_lo;
    logic [VAL_W-1:0] lim_hi;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
  } lim_t;

  diff_t            diff, diff_next;
  lim_t             lim, lim_next;
  logic             diff_valid, lim_valid;
  logic             out_ready, lim_ready, diff_ready;
  logic             min_is, max_is;
  logic [CNT_W+4:0] lo_rep20, hi_rep20;
  logic [VAL_W-1:0] m_above, m_below, m_lo, m_hi;
  logic [VAL_W-1:0] sep_raw, lim_lo_raw, lim_hi_raw;

  assign out_ready  = !result_valid || !result_stall;
  assign lim_ready  = !lim_valid || out_ready;
  assign diff_ready = !diff_valid || lim_ready;
  assign snap_ready = diff_ready;

  // stage one: gates, repeat tests, differences, magnitudes
  always_comb begin
    lo_rep20 = ({5'd0, snap.lo_rep} << 4) + ({5'd0, snap.lo_rep} << 2);
    hi_rep20 = ({5'd0, snap.hi_rep} << 4) + ({5'd0, snap.hi_rep} << 2);
    m_above  = mag(snap.above_lo);
    m_below  = mag(snap.below_hi);
    m_lo     = mag(snap.lo);
    m_hi     = mag(snap.hi);
    diff_next.gate     = (snap.total >= MIN_TOTAL) && (snap.lo != snap.hi);
    diff_next.lo_cand  = snap.above_ok && (snap.lo_rep >= MIN_REPEATS)
                         && (lo_rep20 >= {5'd0, snap.total});
    diff_next.hi_cand  = snap.below_ok && (snap.hi_rep >= MIN_REPEATS)
                         && (hi_rep20 >= {5'd0, snap.total});
    diff_next.range_ok = snap.above_ok && snap.below_ok && lt_s(snap.above_lo, snap.below_hi);
    diff_next.range    = snap.below_hi - snap.above_lo;
    // runners-up lie strictly inside the extremes, so these never wrap
    diff_next.dist_lo  = snap.above_lo - snap.lo;
    diff_next.dist_hi  = snap.hi - snap.below_hi;
    diff_next.mag_lo   = m_lo;
    diff_next.mag_hi   = m_hi;
    diff_next.scale_lo = (m_hi > m_above) ? m_hi : m_above;
    diff_next.scale_hi = (m_lo > m_below) ? m_lo : m_below;
    diff_next.lo       = snap.lo;
    diff_next.hi       = snap.hi;
  end

  // stage two: saturated separation and magnitude limits
  always_comb begin
    sep_raw    = !diff.range_ok ? '0
                 : ((diff.range > SEP_LIM) ? ALL_ONES : mul100(diff.range));
    lim_lo_raw = (diff.scale_lo > LIM_LIM) ? ALL_ONES : mul10000(diff.scale_lo);
    lim_hi_raw = (diff.scale_hi > LIM_LIM) ? ALL_ONES : mul10000(diff.scale_hi);
    lim_next.gate    = diff.gate;
    lim_next.lo_cand = diff.lo_cand;
    lim_next.hi_cand = diff.hi_cand;
    lim_next.sep     = (sep_raw < FIX_ONE) ? FIX_ONE : sep_raw;
    lim_next.dist_lo = diff.dist_lo;
    lim_next.dist_hi = diff.dist_hi;
    lim_next.mag_lo  = diff.mag_lo;
    lim_next.mag_hi  = diff.mag_hi;
    lim_next.lim_lo  = (lim_lo_raw < FIX_MEGA) ? FIX_MEGA : lim_lo_raw;
    lim_next.lim_hi  = (lim_hi_raw < FIX_MEGA) ? FIX_MEGA : lim_hi_raw;
    lim_next.lo      = diff.lo;
    lim_next.hi      = diff.hi;
  end

  // stage three: final compares
  assign min_is = lim.lo_cand && (lim.dist_lo > lim.sep) && (lim.mag_lo > lim.lim_lo);
  assign max_is = lim.hi_cand && (lim.dist_hi > lim.sep) && (lim.mag_hi > lim.lim_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid   <= 1'b0;
      lim_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (diff_ready) begin
        diff_valid <= snap_valid;
      end
      if (lim_ready) begin
        lim_valid <= diff_valid;
      end
      if (out_ready) begin
        result_valid <= lim_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (diff_ready && snap_valid) begin
      diff <= diff_next;
    end
    if (lim_ready && diff_valid) begin
      lim <= lim_next;
    end
    if (out_ready && lim_valid) begin
      nodata_found     <= lim.gate && (min_is != max_is);
      found_at_maximum <= lim.gate && (min_is != max_is) && max_is;
      nodata_value     <= !(lim.gate && (min_is != max_is)) ? '0
                          : (max_is ? lim.hi : lim.lo);
    end
  end

  `REND_ASSERT_ALWAYS(a_empty_result,
    !result_valid || nodata_found || (!found_at_maximum && (nodata_value == '0)))
  `REND_ASSERT_ALWAYS(a_found_nonzero,
    !result_valid || !nodata_found || (nodata_value != '0))
  `REND_ASSERT_NEXT(a_result_held, result_valid && result_stall,
    result_valid && $stable(nodata_value) && $stable(nodata_found))

endmodule

// File: src/repeated_extreme_nodata_detector.sv
// Repeated-extreme no-data detector: takes one sample per cycle while sample_stall is low.
// A result follows the item marked frame_last through the snapshot register,
// two decision stages and the result register; other items give no result.
// Throughput is one item per cycle, held off by sample_stall while a snapshot waits.
// Synchronous reset clears the frame statistics and all pipeline valid flags.
module repeated_extreme_nodata_detector
  import rend_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  logic [63:0]      sample,
  input  logic             sample_finite,
  input  logic             frame_last,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             nodata_found,
  output logic             found_at_maximum,
  output logic [63:0]      nodata_value
);

  logic  take;
  logic  snap_valid, snap_ready, judge_ready;
  stat_t upd, snap;

  // a frame's statistics wait here until the decision pipeline takes them
  assign snap_ready   = !snap_valid || judge_ready;
  assign sample_stall = !snap_ready;
  assign take         = sample_valid && !sample_stall;

  rend_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .sample        (sample),
    .sample_finite (sample_finite),
    .frame_last    (frame_last),
    .upd           (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_ready) begin
      snap_valid <= take && frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (take && frame_last) begin
      snap <= upd;
    end
  end

  rend_judge u_judge (
    .clk              (clk),
    .rst              (rst),
    .snap_valid       (snap_valid),
    .snap             (snap),
    .snap_ready       (judge_ready),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .nodata_found     (nodata_found),
    .found_at_maximum (found_at_maximum),
    .nodata_value     (nodata_value)
  );

endmodule

// File: tb/repeated_extreme_nodata_detector_tb.sv
// Self-checking bench for repeated_extreme_nodata_detector: directed frames, then random
// frames shaped around sentinel extremes, each verdict checked against a typed expectation or a local predictor.
// Depends on rend_pkg and the detector RTL only.
`timescale 1ns / 1ps

module repeated_extreme_nodata_detector_tb
  import rend_pkg::*;
();

  localparam int ITEM_GOAL = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] UNIT = 64'd1 << FRAC_BITS;
  localparam logic [63:0] MEGA = 64'd1000000 << FRAC_BITS;

  typedef struct packed {
    logic [63:0] smp;
    logic        fin;
    logic        last;
  } item_t;

  typedef struct packed {
    logic        found;
    logic        at_max;
    logic [63:0] value;
  } verdict_t;

  typedef struct packed {
    item_t    it;
    logic     typed;
    verdict_t want;
  } row_t;

  localparam verdict_t NO_VERDICT = '0;
  localparam int N_ROWS = 17;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  logic [63:0] sample = '0;
  logic        sample_finite = 1'b0;
  logic        frame_last = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        nodata_found;
  logic        found_at_maximum;
  logic [63:0] nodata_value;

  repeated_extreme_nodata_detector dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .sample(sample), .sample_finite(sample_finite), .frame_last(frame_last),
    .result_valid(result_valid), .result_stall(result_stall),
    .nodata_found(nodata_found), .found_at_maximum(found_at_maximum),
    .nodata_value(nodata_value)
  );

  // Directed frames; typed verdicts only where the answer is plain
  row_t directed_rows [N_ROWS] = '{
    '{'{SMIN, 1'b1, 1'b1}, 1'b1, NO_VERDICT},               // one sample only
    '{'{SMAX, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{SMIN, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{64'd0, 1'b1, 1'b1}, 1'b1, NO_VERDICT},              // rails seen once each
    '{'{64'd5 << FRAC_BITS, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{64'd5 << FRAC_BITS, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{64'd5 << FRAC_BITS, 1'b1, 1'b1}, 1'b1, NO_VERDICT}, // flat frame
    '{'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0}, 1'b0, NO_VERDICT},
    '{'{SMAX, 1'b0, 1'b1}, 1'b1, NO_VERDICT},               // nothing finite
    '{'{64'h5555_5555_5555_5555, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{64'd1, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{SMAX, 1'b0, 1'b1}, 1'b0, NO_VERDICT},               // last item not finite
    '{'{UNIT, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{-UNIT, 1'b1, 1'b0}, 1'b0, NO_VERDICT},
    '{'{64'd0, 1'b1, 1'b1}, 1'b0, NO_VERDICT}
  };

  verdict_t verdicts_due [$];
  item_t    frame_items [$];
  verdict_t got;
  int       fail_count = 0;
  int       items_sent = 0;
  int       sender_idle = 0;
  logic     idle_ok = 1'b1;
  logic     hold_wanted = 1'b0;

  // Frame statistics as the predictor sees them
  logic [CNT_W-1:0]   seen_total, low_reps, high_reps;
  logic signed [63:0] low_val, high_val, next_up, next_down;
  logic               next_up_ok, next_down_ok;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("repeated_extreme_nodata_detector_tb failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t make_item(input logic [63:0] smp, input logic fin);
    item_t it;
    it.smp = smp;
    it.fin = fin;
    it.last = 1'b0;
    return it;
  endfunction

  task automatic append_item(input item_t it);
    frame_items.insert(frame_items.size(), it);
  endtask

  function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] c);
    return (c < MAX_COUNT) ? c + 1'b1 : c;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] gap_between(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] d;
    logic [64:0]        nd;
    d = {a[63], a} - {b[63], b};
    nd = -d;
    return d[64] ? nd[63:0] : d[63:0];
  endfunction

  function automatic logic [63:0] times_sat(input logic [63:0] a, input logic [63:0] k);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, k};
    return (|p[127:64]) ? '1 : p[63:0];
  endfunction

  task automatic clear_stats();
    seen_total = '0;
    low_reps = '0;
    high_reps = '0;
    low_val = '0;
    high_val = '0;
    next_up = '0;
    next_down = '0;
    next_up_ok = 1'b0;
    next_down_ok = 1'b0;
  endtask

  task automatic absorb(input logic signed [63:0] v);
    if (seen_total == 0) begin
      low_val = v;
      high_val = v;
      low_reps = CNT_W'(1);
      high_reps = CNT_W'(1);
      seen_total = CNT_W'(1);
      return;
    end
    seen_total = bump_count(seen_total);
    if (v < low_val) begin
      next_up = low_val;
      next_up_ok = 1'b1;
      low_val = v;
      low_reps = CNT_W'(1);
    end else if (v == low_val) begin
      low_reps = bump_count(low_reps);
    end else if (!next_up_ok || v < next_up) begin
      next_up = v;
      next_up_ok = 1'b1;
    end
    if (v > high_val) begin
      next_down = high_val;
      next_down_ok = 1'b1;
      high_val = v;
      high_reps = CNT_W'(1);
    end else if (v == high_val) begin
      high_reps = bump_count(high_reps);
    end else if (!next_down_ok || v > next_down) begin
      next_down = v;
      next_down_ok = 1'b1;
    end
  endtask

  function automatic logic extreme_qualifies(input logic signed [63:0] ext,
                                             input logic [CNT_W-1:0] reps,
                                             input logic near_ok,
                                             input logic signed [63:0] nearest,
                                             input logic signed [63:0] opposite,
                                             input logic [63:0] sep);
    logic [63:0] scale, lim;
    if (reps < 16 || 64'(reps) * 64'd20 < 64'(seen_total)) return 1'b0;
    if (!near_ok) return 1'b0;
    if (gap_between(nearest, ext) <= sep) return 1'b0;
    scale = abs64(nearest);
    if (abs64(opposite) > scale) scale = abs64(opposite);
    lim = times_sat(scale, 64'd10000);
    if (lim < MEGA) lim = MEGA;
    return abs64(ext) > lim;
  endfunction

  function automatic verdict_t frame_verdict();
    verdict_t    r;
    logic [63:0] width, sep;
    logic        lo_q, hi_q;
    r = NO_VERDICT;
    if (seen_total >= 3 && low_val != high_val) begin
      width = '0;
      if (next_up_ok && next_down_ok && next_up < next_down)
        width = 64'(next_down - next_up);
      sep = times_sat(width, 64'd100);
      if (sep < UNIT) sep = UNIT;
      lo_q = extreme_qualifies(low_val, low_reps, next_up_ok, next_up, high_val, sep);
      hi_q = extreme_qualifies(high_val, high_reps, next_down_ok, next_down, low_val, sep);
      if (lo_q != hi_q) begin
        r.found = 1'b1;
        r.at_max = hi_q;
        r.value = hi_q ? high_val : low_val;
      end
    end
    return r;
  endfunction

  // Offer one item, wait for it to be taken, then update the prediction
  task automatic offer(input item_t it, input logic typed, input verdict_t want);
    verdict_t due;
    if (sender_idle > 0 && $urandom_range(0, sender_idle) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= it.smp;
    sample_finite <= it.fin;
    frame_last <= it.last;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    items_sent++;
    if (it.fin) absorb($signed(it.smp));
    if (it.last) begin
      due = typed ? want : frame_verdict();
      verdicts_due.insert(verdicts_due.size(), due);
      clear_stats();
    end
  endtask

  function automatic logic signed [63:0] sentinel_for(input logic at_max,
                                                      input logic [63:0] ref_mag);
    logic [63:0]        m, u;
    logic signed [63:0] d;
    d = $signed({32'd0, $urandom_range(0, 2)}) - 64'sd1;
    case ($urandom_range(0, 4))
      0: return at_max ? SMAX : SMIN;
      1: m = 64'd9999 << FRAC_BITS;          // too small to be a sentinel
      2: m = MEGA + d;                       // around the absolute floor
      3: m = ref_mag * 64'd10000 + d;        // around the scale-relative floor
      default: begin
        u = rand64();
        m = {2'b01, u[61:0]};
      end
    endcase
    return at_max ? $signed(m) : -$signed(m);
  endfunction

  task automatic compose_frame();
    int                 kind, n, i, j, side, reps;
    logic [63:0]        u, mask, ref_mag;
    logic signed [63:0] base, s;
    logic [1:0]         ends;
    item_t              tmp;
    frame_items.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(1, 6);
      repeat (n) append_item(make_item(rand64(), 1'($urandom_range(0, 1))));
    end else if (kind < 18) begin
      n = $urandom_range(1, 3);
      repeat (n) append_item(make_item(rand64(), 1'b1));
    end else if (kind < 24) begin
      u = $urandom_range(0, 1) ? rand64() : ($urandom_range(0, 1) ? SMAX : SMIN);
      n = $urandom_range(3, 24);
      repeat (n) append_item(make_item(u, 1'b1));
    end else begin
      // interior cluster plus none, one or two repeated extremes
      u = rand64() >> (63 - $urandom_range(0, 44));
      base = $signed(u);
      if ($urandom_range(0, 1)) base = -base;
      mask = (64'd1 << $urandom_range(0, 26)) - 64'd1;
      ref_mag = abs64(base) + mask;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(300, 400) : $urandom_range(1, 40);
      for (i = 0; i < n; i++)
        append_item(make_item(64'(base + $signed(rand64() & mask)), 1'b1));
      j = $urandom_range(0, 9);
      ends = (j < 4) ? 2'b01 : (j < 8) ? 2'b10 : (j == 8) ? 2'b11 : 2'b00;
      for (side = 0; side < 2; side++) begin
        if (ends[side]) begin
          s = sentinel_for(side == 1, ref_mag);
          case ($urandom_range(0, 9))
            0: reps = $urandom_range(1, 3);
            1: reps = $urandom_range(13, 15);
            default: reps = $urandom_range(16, 26);
          endcase
          repeat (reps) append_item(make_item(s, 1'b1));
          // a neighbour right next to the extreme spoils its separation
          if ($urandom_range(0, 9) == 0)
            append_item(make_item((side == 1) ? s - 1 : s + 1, 1'b1));
        end
      end
      repeat ($urandom_range(0, 2)) append_item(make_item(rand64(), 1'b0));
    end
    for (i = frame_items.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = frame_items[i];
      frame_items[i] = frame_items[j];
      frame_items[j] = tmp;
    end
    if ($urandom_range(0, 7) == 0) append_item(make_item(rand64(), 1'b0));
    tmp = frame_items.pop_back();
    tmp.last = 1'b1;
    append_item(tmp);
  endtask

  // Result side: short random stalls, quiet stretches, and one long hold-off
  initial begin : result_side
    int cyc;
    int hold;
    cyc = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        result_stall <= 1'b1;
        for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk);
        result_stall <= 1'b0;
      end else if (idle_ok && (cyc % 256) < 160 && $urandom_range(0, 4) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (verdicts_due.size() == 0) begin
        $error("result with none expected: nodata_found %0b found_at_maximum %0b value %0d",
               nodata_found, found_at_maximum, $signed(nodata_value));
        fail_count++;
      end else begin
        got = verdicts_due.pop_front();
        if (nodata_found !== got.found) begin
          $error("nodata_found: expected %0b, got %0b", got.found, nodata_found);
          fail_count++;
        end
        if (found_at_maximum !== got.at_max) begin
          $error("found_at_maximum: expected %0b, got %0b", got.at_max, found_at_maximum);
          fail_count++;
        end
        if (nodata_value !== got.value) begin
          $error("nodata_value: expected %0d, got %0d",
                 $signed(got.value), $signed(nodata_value));
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int    i;
    item_t it;
    clear_stats();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_ROWS; i++) begin
      sender_idle = $urandom_range(0, 1) * 3;
      offer(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
    end

    // back up the output while single-item frames keep coming
    sender_idle = 0;
    hold_wanted = 1'b1;
    repeat (40) begin
      it = make_item(rand64(), 1'b1);
      it.last = 1'b1;
      offer(it, 1'b0, NO_VERDICT);
    end

    while (items_sent < ITEM_GOAL) begin
      idle_ok = items_sent < ITEM_GOAL * 17 / 20;
      case ($urandom_range(0, 2))
        0: sender_idle = 0;
        1: sender_idle = 2;
        default: sender_idle = 5;
      endcase
      if (!idle_ok) sender_idle = 0;
      compose_frame();
      foreach (frame_items[k]) offer(frame_items[k], 1'b0, NO_VERDICT);
    end
    sample_valid <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0)
      $display("repeated_extreme_nodata_detector_tb passed");
    else
      $display("repeated_extreme_nodata_detector_tb failed");
    $finish;
  end

endmodule
